[hdl/sec2cal_pkg.sv]
package sec2cal_pkg;

    // Pipeline depth: input register through result register
    localparam int STAGES       = 11;
    localparam int CIVIL_FIRST  = 4;
    localparam int CIVIL_STAGES = STAGES - CIVIL_FIRST;

    localparam logic [11:0] BASE_YEAR_RESET = 12'd2008;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [5:0]  MIN_PER_HOUR  = 6'd60;

    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [10:0] DAYS_PER_QUAD = 11'd1460;
    localparam logic [17:0] DAYS_PER_CENT = 18'd36524;
    localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
    localparam logic [6:0]  YEARS_PER_CENT = 7'd100;
    localparam logic [8:0]  YEARS_PER_ERA  = 9'd400;

    // Day numbers count from 1 March of year -400, so every year stays positive.
    // The March-based year holding 1 January of Y is Y - 1, shifted by 400.
    localparam logic [12:0] YEAR_OFFSET = 13'd399;
    localparam logic [8:0]  MAR_TO_JAN  = 9'd306;

    // Constant division: q = (x * ceil(2^S / d)) >> S, exact for x < 2^N when
    // S = N + ceil(log2(d)).
    // seconds / 86400 = (seconds >> 7) / 675, N = 25
    localparam int          DAY_SHIFT  = 35;
    localparam logic [25:0] DAY_RECIP  = 26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
    // shifted year / 100 and / 400, N = 13
    localparam int          CENT_SHIFT = 20;
    localparam logic [13:0] CENT_RECIP = 14'(((64'd1 << CENT_SHIFT) + 64'd99) / 64'd100);
    localparam int          ERA_Y_SHIFT = 22;
    localparam logic [13:0] ERA_Y_RECIP = 14'(((64'd1 << ERA_Y_SHIFT) + 64'd399) / 64'd400);
    // second of day / 60 and / 3600, N = 17
    localparam int          MIN_SHIFT  = 23;
    localparam logic [17:0] MIN_RECIP  = 18'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);
    localparam int          HOUR_SHIFT = 29;
    localparam logic [17:0] HOUR_RECIP = 18'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);
    // day number / 146097, N = 21
    localparam int          ERA_SHIFT  = 39;
    localparam logic [21:0] ERA_RECIP  = 22'(((64'd1 << ERA_SHIFT) + 64'd146096) / 64'd146097);
    // day of era / 1460 and / 365, N = 18
    localparam int          QUAD_SHIFT = 29;
    localparam logic [18:0] QUAD_RECIP = 19'(((64'd1 << QUAD_SHIFT) + 64'd1459) / 64'd1460);
    localparam int          YEAR_SHIFT = 27;
    localparam logic [18:0] YEAR_RECIP = 19'(((64'd1 << YEAR_SHIFT) + 64'd364) / 64'd365);

    // First day of each month within a year that starts on 1 March
    localparam logic [8:0] MONTH_START [0:11] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };
    localparam logic [3:0] MP_JANUARY  = 4'd10;
    localparam logic [3:0] MP_TO_MONTH = 4'd3;
    localparam logic [3:0] MP_WRAP     = 4'd9;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date;

    typedef logic [CIVIL_STAGES-1:0] t_civil_load;

endpackage

[hdl/seconds_to_calendar.sv]
// Converts a 32-bit count of seconds since 1 January 00:00:00 of base_year into a
// Gregorian date and time of day (year, month, day, hour, minute, second), with the
// full leap rule and one result per count. The block is an 11-stage pipeline: it
// takes one count per clock while o_ready is high; the depth is set by the chain
// of reciprocal multiplies that split the count into days, eras and years, and of
// the compares that find the month. A stalled output holds its result while empty
// stages behind it keep filling, so o_ready falls only when all 11 stages hold
// requests. base_year resets to 2008 and is written through i_base_year_we with no
// wait; write it only while no request is in flight. Years past 4095 wrap in the
// 12-bit year field.
module seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_base_year_we,
    input  logic [11:0] i_base_year,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_seconds_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    localparam int LAST  = sec2cal_pkg::STAGES - 1;
    localparam int CFRST = sec2cal_pkg::CIVIL_FIRST;

    logic [LAST:0] r_vld;
    logic [LAST:0] w_load;
    logic [11:0]   r_base_year;

    logic [31:0] r0_cnt;
    logic [11:0] r0_base;

    logic [50:0] n1_day_prod;
    logic [12:0] n1_yp;
    logic [26:0] n1_cent_prod;
    logic [26:0] n1_era_prod;
    logic [31:0] r1_cnt;
    logic [15:0] r1_days;
    logic [12:0] r1_yp;
    logic [5:0]  r1_cents;
    logic [3:0]  r1_eras;

    logic [32:0] n2_day_secs;
    logic [21:0] n2_d0;
    logic [15:0] r2_days;
    logic [16:0] r2_sod;
    logic [20:0] r2_d0;

    logic [34:0] n3_min_prod;
    logic [34:0] n3_hour_prod;
    logic [20:0] r3_z;
    logic [16:0] r3_sod;
    logic [10:0] r3_mins;
    logic [4:0]  r3_hour;

    sec2cal_pkg::t_tod  n4_tod;
    sec2cal_pkg::t_tod  r_tod [CFRST:LAST];
    sec2cal_pkg::t_date w_date;

    // A stage may load when the output side is ready or when it or any stage ahead of it is empty
    for (genvar g = 0; g <= LAST; g++) begin : g_load
        assign w_load[g] = i_ready | ~(&r_vld[LAST:g]);
    end

    assign o_ready = w_load[0];
    assign o_valid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_load[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (w_load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_year <= sec2cal_pkg::BASE_YEAR_RESET;
        end else if (i_base_year_we) begin
            r_base_year <= i_base_year;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r0_cnt  <= i_seconds_count;
            r0_base <= r_base_year;
        end
    end

    // Whole days, and the shifted March-based year before the base year
    assign n1_day_prod  = 51'(r0_cnt[31:7]) * 51'(sec2cal_pkg::DAY_RECIP);
    assign n1_yp        = 13'(r0_base) + sec2cal_pkg::YEAR_OFFSET;
    assign n1_cent_prod = 27'(n1_yp) * 27'(sec2cal_pkg::CENT_RECIP);
    assign n1_era_prod  = 27'(n1_yp) * 27'(sec2cal_pkg::ERA_Y_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_load[1]) begin
            r1_cnt   <= r0_cnt;
            r1_days  <= n1_day_prod[sec2cal_pkg::DAY_SHIFT +: 16];
            r1_yp    <= n1_yp;
            r1_cents <= n1_cent_prod[sec2cal_pkg::CENT_SHIFT +: 6];
            r1_eras  <= n1_era_prod[sec2cal_pkg::ERA_Y_SHIFT +: 4];
        end
    end

    // Day number of 1 January of the base year
    assign n2_day_secs = 33'(r1_days) * 33'(sec2cal_pkg::SECS_PER_DAY);
    assign n2_d0 = 22'(r1_yp) * 22'(sec2cal_pkg::DAYS_PER_YEAR) + 22'(r1_yp[12:2])
                 - 22'(r1_cents) + 22'(r1_eras) + 22'(sec2cal_pkg::MAR_TO_JAN);

    always_ff @(posedge i_clk) begin
        if (w_load[2]) begin
            r2_days <= r1_days;
            r2_sod  <= 17'(33'(r1_cnt) - n2_day_secs);
            r2_d0   <= n2_d0[20:0];
        end
    end

    assign n3_min_prod  = 35'(r2_sod) * 35'(sec2cal_pkg::MIN_RECIP);
    assign n3_hour_prod = 35'(r2_sod) * 35'(sec2cal_pkg::HOUR_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_load[3]) begin
            r3_z    <= r2_d0 + 21'(r2_days);
            r3_sod  <= r2_sod;
            r3_mins <= n3_min_prod[sec2cal_pkg::MIN_SHIFT +: 11];
            r3_hour <= n3_hour_prod[sec2cal_pkg::HOUR_SHIFT +: 5];
        end
    end

    always_comb begin
        n4_tod.hour   = r3_hour;
        n4_tod.minute = 6'(r3_mins - 11'(r3_hour) * 11'(sec2cal_pkg::MIN_PER_HOUR));
        n4_tod.second = 6'(r3_sod - 17'(r3_mins) * 17'(sec2cal_pkg::SECS_PER_MIN));
    end

    // Carry the time of day alongside the date stages
    always_ff @(posedge i_clk) begin
        if (w_load[CFRST]) begin
            r_tod[CFRST] <= n4_tod;
        end
        for (int k = CFRST + 1; k <= LAST; k++) begin
            if (w_load[k]) begin
                r_tod[k] <= r_tod[k-1];
            end
        end
    end

    sec2cal_civil u_civil (
        .i_clk  (i_clk),
        .i_load (w_load[LAST:CFRST]),
        .i_z    (r3_z),
        .o_date (w_date)
    );

    assign o_year         = w_date.year;
    assign o_month        = w_date.month;
    assign o_day_of_month = w_date.day;
    assign o_hour         = r_tod[LAST].hour;
    assign o_minute       = r_tod[LAST].minute;
    assign o_second       = r_tod[LAST].second;

endmodule

[hdl/sec2cal_civil.sv]
module sec2cal_civil (
    input  logic                      i_clk,
    input  sec2cal_pkg::t_civil_load  i_load,
    input  logic [20:0]               i_z,
    output sec2cal_pkg::t_date        o_date
);

    logic [42:0] n0_era_prod;
    logic [20:0] r0_z;
    logic [3:0]  r0_era;

    logic [17:0] r1_doe;
    logic [3:0]  r1_era;

    logic [36:0] n2_quad_prod;
    logic [2:0]  n2_cents;
    logic [17:0] r2_doe;
    logic [3:0]  r2_era;
    logic [6:0]  r2_quads;
    logic [2:0]  r2_cents;
    logic        r2_last;

    logic [17:0] r3_t;
    logic [17:0] r3_doe;
    logic [3:0]  r3_era;

    logic [36:0] n4_yoe_prod;
    logic [8:0]  r4_yoe;
    logic [17:0] r4_doe;
    logic [3:0]  r4_era;

    logic [1:0]  n5_cents;
    logic [17:0] n5_year_days;
    logic [8:0]  r5_doy;
    logic [8:0]  r5_yoe;
    logic [3:0]  r5_era;

    logic [3:0]  n6_mp;
    logic        n6_jan_feb;
    logic [12:0] n6_year;
    sec2cal_pkg::t_date n6_date;
    sec2cal_pkg::t_date r6_date;

    assign n0_era_prod = 43'(i_z) * 43'(sec2cal_pkg::ERA_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r0_z   <= i_z;
            r0_era <= n0_era_prod[sec2cal_pkg::ERA_SHIFT +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r1_doe <= 18'(r0_z - 21'(r0_era) * 21'(sec2cal_pkg::DAYS_PER_ERA));
            r1_era <= r0_era;
        end
    end

    // Century count within the era by compare; the last day of an era is its own case
    assign n2_quad_prod = 37'(r1_doe) * 37'(sec2cal_pkg::QUAD_RECIP);
    assign n2_cents = 3'(r1_doe >= sec2cal_pkg::DAYS_PER_CENT)
                    + 3'(r1_doe >= 18'(2 * sec2cal_pkg::DAYS_PER_CENT))
                    + 3'(r1_doe >= 18'(3 * sec2cal_pkg::DAYS_PER_CENT))
                    + 3'(r1_doe >= 18'(4 * sec2cal_pkg::DAYS_PER_CENT));

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r2_doe   <= r1_doe;
            r2_era   <= r1_era;
            r2_quads <= n2_quad_prod[sec2cal_pkg::QUAD_SHIFT +: 7];
            r2_cents <= n2_cents;
            r2_last  <= (r1_doe == 18'(4 * sec2cal_pkg::DAYS_PER_CENT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r3_t   <= r2_doe - 18'(r2_quads) + 18'(r2_cents) - 18'(r2_last);
            r3_doe <= r2_doe;
            r3_era <= r2_era;
        end
    end

    assign n4_yoe_prod = 37'(r3_t) * 37'(sec2cal_pkg::YEAR_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r4_yoe <= n4_yoe_prod[sec2cal_pkg::YEAR_SHIFT +: 9];
            r4_doe <= r3_doe;
            r4_era <= r3_era;
        end
    end

    assign n5_cents = 2'(r4_yoe >= 9'(sec2cal_pkg::YEARS_PER_CENT))
                    + 2'(r4_yoe >= 9'(2 * sec2cal_pkg::YEARS_PER_CENT))
                    + 2'(r4_yoe >= 9'(3 * sec2cal_pkg::YEARS_PER_CENT));
    assign n5_year_days = 18'(r4_yoe) * 18'(sec2cal_pkg::DAYS_PER_YEAR)
                        + 18'(r4_yoe[8:2]) - 18'(n5_cents);

    always_ff @(posedge i_clk) begin
        if (i_load[5]) begin
            r5_doy <= 9'(r4_doe - n5_year_days);
            r5_yoe <= r4_yoe;
            r5_era <= r4_era;
        end
    end

    // Month within the March-based year by compare against the month starts
    always_comb begin
        n6_mp = '0;
        for (int k = 1; k < 12; k++) begin
            n6_mp = n6_mp + 4'(r5_doy >= sec2cal_pkg::MONTH_START[k]);
        end
        n6_jan_feb = (n6_mp >= sec2cal_pkg::MP_JANUARY);
        n6_year = 13'(r5_yoe) + 13'(r5_era) * 13'(sec2cal_pkg::YEARS_PER_ERA)
                + 13'(n6_jan_feb) - 13'(sec2cal_pkg::YEARS_PER_ERA);
        n6_date.year  = n6_year[11:0];
        n6_date.month = n6_jan_feb ? (n6_mp - sec2cal_pkg::MP_WRAP)
                                   : (n6_mp + sec2cal_pkg::MP_TO_MONTH);
        n6_date.day   = 5'(r5_doy - sec2cal_pkg::MONTH_START[n6_mp] + 9'd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_load[6]) begin
            r6_date <= n6_date;
        end
    end

    assign o_date = r6_date;

endmodule

[hdl/sec2cal_chk.sv]
module sec2cal_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_year,
    input logic [3:0]  i_month,
    input logic [4:0]  i_day,
    input logic [4:0]  i_hour,
    input logic [5:0]  i_minute,
    input logic [5:0]  i_second
);

    // Hold a stalled result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_year) && $stable(i_month) && $stable(i_day)
             && $stable(i_hour) && $stable(i_minute) && $stable(i_second)))
        else $error("result changed while stalled");

    // Back-pressure reaches the input only with a result waiting at the output
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result waiting");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_month >= 4'd1 && i_month <= 4'd12 && i_day >= 5'd1
                         && (i_month != 4'd2 || i_day <= 5'd29)))
        else $error("date out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_hour <= 5'd23 && i_minute <= 6'd59 && i_second <= 6'd59))
        else $error("time of day out of range");

endmodule

bind seconds_to_calendar sec2cal_chk u_sec2cal_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_year      (o_year),
    .i_month     (o_month),
    .i_day       (o_day_of_month),
    .i_hour      (o_hour),
    .i_minute    (o_minute),
    .i_second    (o_second)
);
